// ===== rtl/mlfq_pkg.sv =====
// Shared types and constants of the feedback-queue scheduler.
// Used by mlfq_process_scheduler_unit; no dependencies.
package mlfq_pkg;

    localparam int MLFQ_SLOTS      = 64;
    localparam int MLFQ_STAMP_BITS = 32;
    localparam int SCHED_LEVELS    = 4;

    // reset quanta per level
    localparam logic [7:0] QUANTUM_RESET [SCHED_LEVELS] = '{8'd1, 8'd4, 8'd8, 8'd16};

    // slot status codes
    localparam logic [1:0] ST_UNUSED   = 2'd0;
    localparam logic [1:0] ST_SLEEPING = 2'd1;
    localparam logic [1:0] ST_RUNNABLE = 2'd2;
    localparam logic [1:0] ST_RUNNING  = 2'd3;

    // operation codes
    localparam logic [3:0] OP_ADMIT  = 4'd0;
    localparam logic [3:0] OP_WAKE   = 4'd1;
    localparam logic [3:0] OP_TICK   = 4'd2;
    localparam logic [3:0] OP_TYIELD = 4'd3;
    localparam logic [3:0] OP_VYIELD = 4'd4;
    localparam logic [3:0] OP_SLEEP  = 4'd5;
    localparam logic [3:0] OP_FREE   = 4'd6;
    localparam logic [3:0] OP_BOOST  = 4'd7;
    localparam logic [3:0] OP_PICK   = 4'd8;

    localparam logic [1:0] LEVEL_LAST = 2'(SCHED_LEVELS - 1);
    localparam logic [7:0] SLICE_MAX  = 8'd255;

    // per-slot bookkeeping word
    typedef struct packed {
        logic [1:0] status;
        logic [1:0] level;
        logic [7:0] slice;
    } t_meta;

    localparam int META_BITS = $bits(t_meta);

endpackage

// ===== rtl/mlfq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mlfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/mlfq_process_scheduler_unit.sv =====
// Four-level feedback-queue scheduler: slot table in RAM, one sequencer.
// Depends on mlfq_pkg and mlfq_ram.
// Admit, wake, free and tick/yield/sleep (slot running) read and update the slot entry; tick then scans
// all slots, boost scans them, pick scans them if none runs, then takes the best. The scan reads,
// then evaluates, each entry; every request ends by reading the current slot. One request at a
// time, taken in idle after the last result. Reset is synchronous; valid bits clear at once.
module mlfq_process_scheduler_unit
    import mlfq_pkg::*;
#(
    parameter int SLOTS      = MLFQ_SLOTS,
    parameter int STAMP_BITS = MLFQ_STAMP_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [3:0] i_operation,
    input  logic [5:0] i_slot,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_preempt,
    output logic       o_found,
    output logic [5:0] o_chosen_slot,
    output logic [1:0] o_chosen_level,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [2:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    localparam int SW = $clog2(SLOTS);

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_RD      = 8'b0000_0010,
        S_EVAL    = 8'b0000_0100,
        S_SCAN_RD = 8'b0000_1000,
        S_SCAN_EV = 8'b0001_0000,
        S_CUR_RD  = 8'b0010_0000,
        S_CUR_EV  = 8'b0100_0000,
        S_OUT     = 8'b1000_0000
    } t_state;

    t_state                r_state, n_state;
    logic [3:0]            r_op, n_op;
    logic [SW-1:0]         r_addr, n_addr;
    logic [SW-1:0]         r_idx, n_idx;
    logic [SW-1:0]         r_cur, n_cur;
    logic                  r_cur_vld, n_cur_vld;
    logic [1:0]            r_cur_lvl, n_cur_lvl;
    logic [STAMP_BITS-1:0] r_stamp, n_stamp;
    logic                  r_have, n_have;
    logic [SW-1:0]         r_best, n_best;
    logic [1:0]            r_best_lvl, n_best_lvl;
    logic [STAMP_BITS-1:0] r_best_stamp, n_best_stamp;
    logic                  r_preempt, n_preempt;
    logic                  r_found, n_found;
    logic [1:0]            r_level, n_level;
    logic [7:0]            r_q [SCHED_LEVELS];
    logic [SLOTS-1:0]      r_vld, n_vld;
    logic                  r_rvld;

    logic [SW-1:0]         raddr;
    logic                  mwe;
    logic [SW-1:0]         mwaddr;
    t_meta                 mwdata;
    logic [META_BITS-1:0]  mrdata;
    logic                  swe;
    logic [SW-1:0]         swaddr;
    logic [STAMP_BITS-1:0] srdata;
    t_meta                 m;

    mlfq_ram #(.WIDTH(META_BITS), .DEPTH(SLOTS)) u_meta (
        .i_clk   (i_clk),
        .i_we    (mwe),
        .i_waddr (mwaddr),
        .i_wdata (mwdata),
        .i_raddr (raddr),
        .o_rdata (mrdata)
    );

    mlfq_ram #(.WIDTH(STAMP_BITS), .DEPTH(SLOTS)) u_stamp (
        .i_clk   (i_clk),
        .i_we    (swe),
        .i_waddr (swaddr),
        .i_wdata (n_stamp),
        .i_raddr (raddr),
        .o_rdata (srdata)
    );

    // unwritten entries read as the reset value
    assign m = r_rvld ? t_meta'(mrdata) : '0;

    // select read address
    always_comb begin
        case (r_state)
            S_RD:      raddr = r_addr;
            S_SCAN_RD: raddr = r_idx;
            S_CUR_RD:  raddr = r_cur;
            default:   raddr = r_addr;
        endcase
    end

    // sequencer and shared compare unit
    always_comb begin
        logic [7:0]            slc;
        logic [7:0]            q;
        logic                  spent;
        logic                  take;
        logic [STAMP_BITS-1:0] diff;
        logic                  last;
        n_state      = r_state;
        n_op         = r_op;
        n_addr       = r_addr;
        n_idx        = r_idx;
        n_cur        = r_cur;
        n_cur_vld    = r_cur_vld;
        n_cur_lvl    = r_cur_lvl;
        n_stamp      = r_stamp;
        n_have       = r_have;
        n_best       = r_best;
        n_best_lvl   = r_best_lvl;
        n_best_stamp = r_best_stamp;
        n_preempt    = r_preempt;
        n_found      = r_found;
        n_level      = r_level;
        n_vld        = r_vld;
        mwe          = 1'b0;
        mwaddr       = r_addr;
        mwdata       = m;
        swe          = 1'b0;
        swaddr       = r_addr;
        q            = r_q[m.level];
        slc          = (m.slice < SLICE_MAX) ? m.slice + 8'd1 : m.slice;
        spent        = m.slice >= q;
        diff         = srdata - r_best_stamp;
        take         = 1'b0;
        last         = r_idx == SW'(SLOTS - 1);
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_op      = i_operation;
                    n_preempt = 1'b0;
                    n_found   = 1'b0;
                    n_idx     = '0;
                    n_have    = 1'b0;
                    n_state   = S_CUR_RD;
                    case (i_operation)
                        OP_ADMIT, OP_WAKE, OP_FREE: begin
                            n_addr = SW'(i_slot);
                            if (32'(i_slot) < SLOTS) n_state = S_RD;
                        end
                        OP_TICK, OP_TYIELD, OP_VYIELD, OP_SLEEP: begin
                            n_addr = r_cur;
                            if (r_cur_vld) n_state = S_RD;
                        end
                        OP_BOOST: n_state = S_SCAN_RD;
                        OP_PICK: begin
                            if (!r_cur_vld) n_state = S_SCAN_RD;
                        end
                        default: n_state = S_CUR_RD;
                    endcase
                end
            end
            S_RD: n_state = S_EVAL;
            S_EVAL: begin
                n_state = S_CUR_RD;
                mwe     = 1'b1;
                case (r_op)
                    OP_ADMIT: begin
                        mwdata = '{status: ST_RUNNABLE, level: 2'd0, slice: 8'd0};
                        swe    = 1'b1;
                        if (r_cur == r_addr) n_cur_vld = 1'b0;
                    end
                    OP_WAKE: begin
                        mwdata.status = ST_RUNNABLE;
                        mwe = m.status == ST_SLEEPING;
                        swe = m.status == ST_SLEEPING;
                    end
                    OP_FREE: begin
                        mwdata.status = ST_UNUSED;
                        if (r_cur == r_addr) n_cur_vld = 1'b0;
                    end
                    OP_TICK: begin
                        mwdata.slice = slc;
                        n_preempt    = slc >= q;
                        n_cur_lvl    = m.level;
                        n_state      = S_SCAN_RD;
                    end
                    OP_TYIELD: begin
                        mwdata.status = ST_RUNNABLE;
                        if (spent) begin
                            mwdata.slice = 8'd0;
                            if (m.level != LEVEL_LAST) mwdata.level = m.level + 2'd1;
                        end
                        swe       = 1'b1;
                        n_cur_vld = 1'b0;
                    end
                    OP_VYIELD: begin
                        mwdata.status = ST_RUNNABLE;
                        swe       = 1'b1;
                        n_cur_vld = 1'b0;
                    end
                    OP_SLEEP: begin
                        mwdata.status = ST_SLEEPING;
                        n_cur_vld = 1'b0;
                    end
                    OP_PICK: begin
                        mwdata.status = ST_RUNNING;
                        n_cur     = r_addr;
                        n_cur_vld = 1'b1;
                        n_found   = 1'b1;
                    end
                    default: mwe = 1'b0;
                endcase
            end
            S_SCAN_RD: n_state = S_SCAN_EV;
            S_SCAN_EV: begin
                mwaddr = r_idx;
                swaddr = r_idx;
                case (r_op)
                    OP_TICK: begin
                        if (m.status == ST_RUNNABLE && m.level < r_cur_lvl) n_preempt = 1'b1;
                    end
                    OP_BOOST: begin
                        mwdata.level = 2'd0;
                        mwdata.slice = 8'd0;
                        mwe = m.status != ST_UNUSED;
                        swe = m.status == ST_RUNNABLE;
                    end
                    OP_PICK: begin
                        take = m.status == ST_RUNNABLE && (!r_have || m.level < r_best_lvl
                               || (m.level == r_best_lvl && diff[STAMP_BITS-1]));
                        if (take) begin
                            n_have       = 1'b1;
                            n_best       = r_idx;
                            n_best_lvl   = m.level;
                            n_best_stamp = srdata;
                        end
                    end
                    default: n_preempt = r_preempt;
                endcase
                if (last) begin
                    n_state = S_CUR_RD;
                    if (r_op == OP_PICK && n_have) begin
                        n_addr  = n_best;
                        n_state = S_RD;
                    end
                end else begin
                    n_idx   = r_idx + SW'(1);
                    n_state = S_SCAN_RD;
                end
            end
            S_CUR_RD: n_state = S_CUR_EV;
            S_CUR_EV: begin
                n_level = m.level;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_stall) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
        // advance stamp on every enqueue, mark written entries
        if (swe) n_stamp = r_stamp + STAMP_BITS'(1);
        if (mwe) n_vld[mwaddr] = 1'b1;
    end

    // hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cur     <= '0;
            r_cur_vld <= 1'b0;
            r_stamp   <= '0;
            r_vld     <= '0;
            r_rvld    <= 1'b0;
            for (int k = 0; k < SCHED_LEVELS; k++) r_q[k] <= QUANTUM_RESET[k];
        end else begin
            r_state   <= n_state;
            r_cur     <= n_cur;
            r_cur_vld <= n_cur_vld;
            r_stamp   <= n_stamp;
            r_vld     <= n_vld;
            r_rvld    <= r_vld[raddr];
            if (i_cfg_valid && 32'(i_cfg_index) < SCHED_LEVELS) begin
                r_q[i_cfg_index[1:0]] <= i_cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_addr       <= n_addr;
        r_idx        <= n_idx;
        r_cur_lvl    <= n_cur_lvl;
        r_have       <= n_have;
        r_best       <= n_best;
        r_best_lvl   <= n_best_lvl;
        r_best_stamp <= n_best_stamp;
        r_preempt    <= n_preempt;
        r_found      <= n_found;
        r_level      <= n_level;
    end

    assign o_stall        = r_state != S_IDLE;
    assign o_valid        = r_state == S_OUT;
    assign o_preempt      = r_preempt;
    assign o_found        = r_found;
    assign o_chosen_slot  = 6'(r_cur);
    assign o_chosen_level = r_level;
    assign o_cfg_ready    = 1'b1;

    // a stamp only moves forward by one
    a_stamp_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_stamp != $past(r_stamp))
        |-> r_stamp == $past(r_stamp) + STAMP_BITS'(1))
        else $error("stamp counter skipped");

    // a found pick leaves a running slot
    a_found_cur: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_found) |-> r_cur_vld)
        else $error("pick reported without current slot");

    // preempt and found never both
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_preempt && o_found))
        else $error("preempt and found together");

    // no request taken while a result waits
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input open while result pending");

endmodule

// ===== bench/tb_mlfq_process_scheduler_unit.sv =====
// Self-checking bench for the four-level feedback-queue scheduler.
// Drives requests and register writes and checks every result against its own predictor.
// Depends on mlfq_pkg and mlfq_process_scheduler_unit.
module tb_mlfq_process_scheduler_unit
    import mlfq_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 300;

    typedef struct packed {
        logic       preempt;
        logic       found;
        logic [5:0] slot;
        logic [1:0] level;
    } t_sched_answer;

    // Predicted scheduler state and the queue of answers still to come
    class t_sched_scoreboard;
        logic [1:0]    status [MLFQ_SLOTS];
        logic [1:0]    level [MLFQ_SLOTS];
        logic [7:0]    slice [MLFQ_SLOTS];
        logic [31:0]   stamp [MLFQ_SLOTS];
        logic [31:0]   stamp_counter;
        logic [5:0]    cur_slot;
        logic          cur_valid;
        logic [7:0]    quantum [SCHED_LEVELS];
        t_sched_answer answers_q [$];
        int            errors;

        function new();
            for (int i = 0; i < MLFQ_SLOTS; i++) begin
                status[i] = ST_UNUSED;
                level[i]  = '0;
                slice[i]  = '0;
                stamp[i]  = '0;
            end
            for (int q = 0; q < SCHED_LEVELS; q++) quantum[q] = QUANTUM_RESET[q];
            stamp_counter = '0;
            cur_slot      = '0;
            cur_valid     = 1'b0;
            errors        = 0;
        endfunction

        function void restamp(int s);
            stamp_counter = stamp_counter + 32'd1;
            stamp[s]      = stamp_counter;
        endfunction

        function void note_config(logic [2:0] idx, logic [7:0] data);
            if (idx < SCHED_LEVELS) quantum[idx] = data;
        endfunction

        // Apply one request to the predicted state and queue its answer
        function void note_request(logic [3:0] op, logic [5:0] s);
            t_sched_answer ans;
            int            best;
            logic [31:0]   diff;
            ans  = '0;
            best = -1;
            case (op)
                OP_ADMIT: begin
                    if (cur_valid && cur_slot == s) cur_valid = 1'b0;
                    status[s] = ST_RUNNABLE;
                    level[s]  = '0;
                    slice[s]  = '0;
                    restamp(s);
                end
                OP_WAKE: begin
                    if (status[s] == ST_SLEEPING) begin
                        status[s] = ST_RUNNABLE;
                        restamp(s);
                    end
                end
                OP_TICK: begin
                    if (cur_valid) begin
                        if (slice[cur_slot] != SLICE_MAX) slice[cur_slot]++;
                        if (slice[cur_slot] >= quantum[level[cur_slot]]) ans.preempt = 1'b1;
                        for (int i = 0; i < MLFQ_SLOTS; i++)
                            if (status[i] == ST_RUNNABLE && level[i] < level[cur_slot])
                                ans.preempt = 1'b1;
                    end
                end
                OP_TYIELD: begin
                    if (cur_valid) begin
                        if (slice[cur_slot] >= quantum[level[cur_slot]]) begin
                            if (level[cur_slot] != LEVEL_LAST) level[cur_slot]++;
                            slice[cur_slot] = '0;
                        end
                        status[cur_slot] = ST_RUNNABLE;
                        restamp(cur_slot);
                        cur_valid = 1'b0;
                    end
                end
                OP_VYIELD: begin
                    if (cur_valid) begin
                        status[cur_slot] = ST_RUNNABLE;
                        restamp(cur_slot);
                        cur_valid = 1'b0;
                    end
                end
                OP_SLEEP: begin
                    if (cur_valid) begin
                        status[cur_slot] = ST_SLEEPING;
                        cur_valid = 1'b0;
                    end
                end
                OP_FREE: begin
                    if (cur_valid && cur_slot == s) cur_valid = 1'b0;
                    status[s] = ST_UNUSED;
                end
                OP_BOOST: begin
                    for (int i = 0; i < MLFQ_SLOTS; i++) begin
                        if (status[i] != ST_UNUSED) begin
                            level[i] = '0;
                            slice[i] = '0;
                            if (status[i] == ST_RUNNABLE) restamp(i);
                        end
                    end
                end
                OP_PICK: begin
                    if (!cur_valid) begin
                        // lowest level first, then oldest stamp, then lowest index
                        for (int i = 0; i < MLFQ_SLOTS; i++) begin
                            if (status[i] != ST_RUNNABLE) continue;
                            if (best < 0) best = i;
                            else begin
                                diff = stamp[i] - stamp[best];
                                if (level[i] < level[best] ||
                                    (level[i] == level[best] && diff[31]))
                                    best = i;
                            end
                        end
                        if (best >= 0) begin
                            status[best] = ST_RUNNING;
                            cur_slot     = 6'(best);
                            cur_valid    = 1'b1;
                            ans.found    = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
            ans.slot  = cur_slot;
            ans.level = level[cur_slot];
            answers_q.push_back(ans);
        endfunction

        // Compare one answer with the oldest prediction
        function void check_result(t_sched_answer got);
            t_sched_answer want;
            if (answers_q.size() == 0) begin
                $display("%0t: unexpected result %p", $time, got);
                errors++;
                return;
            end
            want = answers_q.pop_front();
            if (got.preempt !== want.preempt) begin
                $display("%0t: preempt expected %0d actual %0d",
                         $time, want.preempt, got.preempt);
                errors++;
            end
            if (got.found !== want.found) begin
                $display("%0t: found expected %0d actual %0d",
                         $time, want.found, got.found);
                errors++;
            end
            if (got.slot !== want.slot) begin
                $display("%0t: chosen_slot expected %0d actual %0d",
                         $time, want.slot, got.slot);
                errors++;
            end
            if (got.level !== want.level) begin
                $display("%0t: chosen_level expected %0d actual %0d",
                         $time, want.level, got.level);
                errors++;
            end
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic [3:0] i_operation = '0;
    logic [5:0] i_slot = '0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic       o_preempt;
    logic       o_found;
    logic [5:0] o_chosen_slot;
    logic [1:0] o_chosen_level;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [2:0] i_cfg_index = '0;
    logic [7:0] i_cfg_data = '0;

    t_sched_scoreboard sched_sb = new();
    int idle_cycles = 0;
    int stall_left  = 0;
    int flow_left   = 0;

    mlfq_process_scheduler_unit dut (.*);

    always #5 i_clk = ~i_clk;

    // Watch all three channels, feed the scoreboard and guard against a hang
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall)
                sched_sb.check_result({o_preempt, o_found, o_chosen_slot, o_chosen_level});
            if (i_valid && !o_stall) sched_sb.note_request(i_operation, i_slot);
            if (i_cfg_valid && o_cfg_ready) sched_sb.note_config(i_cfg_index, i_cfg_data);
            if ((o_valid && !i_stall) || (i_valid && !o_stall) || (i_cfg_valid && o_cfg_ready))
                idle_cycles <= 0;
            else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("mlfq_process_scheduler_unit test failed");
                $finish;
            end else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Stall the result side in bursts, with stretches of free flow between them
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall    <= 1'b1;
        end else if (flow_left > 0) begin
            flow_left <= flow_left - 1;
            i_stall   <= 1'b0;
        end else if ($urandom_range(0, 2) == 0) begin
            flow_left <= $urandom_range(5, 60);
            i_stall   <= 1'b0;
        end else begin
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                       : $urandom_range(0, 3);
            i_stall    <= 1'b1;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 88) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    // Hand one request over, keeping valid high when the next follows at once
    task automatic send_request(logic [3:0] op, logic [5:0] s);
        int gap;
        gap = gap_len();
        if (gap > 0 && i_valid) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_operation <= op;
        i_slot      <= s;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic release_requests();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_idle();
        release_requests();
        while (sched_sb.answers_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_quantum(logic [2:0] idx, logic [7:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_quanta(logic [7:0] q0, logic [7:0] q1, logic [7:0] q2, logic [7:0] q3);
        wait_idle();
        write_quantum(3'd0, q0);
        write_quantum(3'd1, q1);
        write_quantum(3'd2, q2);
        write_quantum(3'd3, q3);
    endtask

    // Mostly scheduling traffic on a few slots, some wide slot numbers and junk codes
    task automatic random_requests(int count);
        logic [3:0] op;
        logic [5:0] s;
        int         r;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 14) op = OP_ADMIT;
            else if (r < 22) op = OP_WAKE;
            else if (r < 46) op = OP_TICK;
            else if (r < 56) op = OP_TYIELD;
            else if (r < 62) op = OP_VYIELD;
            else if (r < 69) op = OP_SLEEP;
            else if (r < 74) op = OP_FREE;
            else if (r < 77) op = OP_BOOST;
            else if (r < 97) op = OP_PICK;
            else op = 4'($urandom_range(9, 15));
            s = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63))
                                            : 6'($urandom_range(0, 7));
            send_request(op, s);
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, every operation and the corner cases
        send_request(OP_TICK, 6'd0);       // nothing running
        send_request(OP_PICK, 6'd0);       // nothing runnable
        send_request(OP_ADMIT, 6'd63);
        send_request(OP_ADMIT, 6'd0);
        send_request(OP_PICK, 6'd0);       // takes slot 63, oldest
        send_request(OP_PICK, 6'd0);       // pick while running
        send_request(OP_TICK, 6'd0);       // quantum spent
        send_request(OP_TYIELD, 6'd0);     // demote to level 1
        send_request(OP_PICK, 6'd0);
        send_request(OP_TICK, 6'd0);       // quantum spent; only a lower-priority slot runnable
        send_request(OP_VYIELD, 6'd0);
        send_request(OP_PICK, 6'd0);
        send_request(OP_SLEEP, 6'd0);
        send_request(OP_WAKE, 6'd0);       // sleeping: made runnable again
        send_request(OP_WAKE, 6'd63);
        send_request(OP_PICK, 6'd0);
        send_request(OP_FREE, 6'd63);      // free a runnable slot that is not running
        send_request(OP_ADMIT, 6'd42);
        send_request(OP_PICK, 6'd0);
        send_request(OP_ADMIT, 6'd21);     // admit an unused slot
        send_request(OP_BOOST, 6'd0);
        send_request(4'd9, 6'd0);
        send_request(4'd15, 6'd63);
        random_requests(60);

        // Quanta of all extremes, then zero quantum and unused register indexes
        set_quanta(8'd255, 8'd255, 8'd255, 8'd255);
        random_requests(100);
        set_quanta(8'd0, 8'd1, 8'd2, 8'd0);
        write_quantum(3'd4, 8'hAA);
        write_quantum(3'd7, 8'h55);
        random_requests(100);
        set_quanta(8'd1, 8'd2, 8'd3, 8'd4);
        random_requests(100);
        set_quanta(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                   8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)));
        random_requests(70);
        set_quanta(8'd1, 8'd4, 8'd8, 8'd16);
        random_requests(100);

        // Drain everything outstanding, then allow the tail latency
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sched_sb.errors == 0 && sched_sb.answers_q.size() == 0)
            $display("mlfq_process_scheduler_unit test passed");
        else
            $display("mlfq_process_scheduler_unit test failed");
        $finish;
    end

endmodule
